>>> src/transposition_table_probe_store_defines.svh
// Assertion macros for the transposition table probe store.
// Included by the top level; no other dependencies.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH

`ifndef SYNTH
`define TTPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/ttps_pkg.sv
// Shared types and constants for the transposition table probe store.
// No dependencies.
`default_nettype none

package ttps_pkg;

  typedef enum logic [1:0] {
    KIND_PROBE     = 2'd0,
    KIND_RECORD    = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_OCCUPANCY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_MISS = 2'd0,
    STAT_CUT  = 2'd1,
    STAT_MOVE = 2'd2,
    STAT_DONE = 2'd3
  } status_t;

  localparam logic [1:0] FLAG_EXACT = 2'd0;
  localparam logic [1:0] FLAG_UPPER = 2'd1;
  localparam logic [1:0] FLAG_LOWER = 2'd2;

  localparam int KEY_W          = 64;
  localparam int PERMILLE_SCALE = 1000;
  localparam logic [14:0] MATE_THR_RESET = 15'd29000;

  localparam logic signed [16:0] SAT_MAX = 17'sd32767;
  localparam logic signed [16:0] SAT_MIN = -17'sd32768;

  // entry payload, 41 bits
  typedef struct packed {
    logic [15:0]        move;
    logic [6:0]         depth;
    logic [1:0]         flag;
    logic signed [15:0] score;
  } payload_t;

  typedef struct packed {
    logic capture;      // latch item, issue table read
    logic sweep_start;  // clear op accepted
    logic sweep_step;   // zero one entry
    logic commit;       // finish item, load result register
  } ttps_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } ttps_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7FFF;
    end else if (v < SAT_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/ttps_ctrl.sv
// Controller FSM: handshakes, sweep sequencing and result register valid.
// Depends on ttps_pkg.
`default_nettype none

module ttps_ctrl
  import ttps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_kind,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire ttps_stat_t stat,
  output ttps_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   init_r;
  logic   out_valid_r;
  logic   accept;
  logic   slot_free;
  logic   is_clear;

  always_comb begin
    is_clear        = (kind_t'(in_kind) == KIND_CLEAR);
    accept          = (state_r == S_IDLE) && in_valid;
    slot_free       = !out_valid_r || out_ready;
    cmd.capture     = accept;
    cmd.sweep_start = accept && is_clear;
    cmd.sweep_step  = (state_r == S_SWEEP);
    cmd.commit      = (state_r == S_EXEC) && slot_free;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit | (out_valid_r & ~out_ready);
      unique case (state_r)
        S_SWEEP: begin
          if (stat.sweep_last) begin
            // power-up pass gives no result; a clear op does
            state_r <= init_r ? S_IDLE : S_EXEC;
            init_r  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= is_clear ? S_SWEEP : S_EXEC;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/ttps_dp.sv
// Datapath: entry table memory, mate score adjust, probe/record logic,
// occupancy count and result register. Depends on ttps_pkg.
`default_nettype none

module ttps_dp
  import ttps_pkg::*;
#(
  parameter int ENTRIES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          in_kind,
  input  wire logic [63:0]         in_position_key,
  input  wire logic signed [15:0]  in_alpha_bound,
  input  wire logic signed [15:0]  in_beta_bound,
  input  wire logic [6:0]          in_search_depth,
  input  wire logic [6:0]          in_ply_from_root,
  input  wire logic signed [15:0]  in_store_score,
  input  wire logic [1:0]          in_store_flag,
  input  wire logic [15:0]         in_store_move,
  input  wire logic                cfg_wr_en,
  input  wire logic [14:0]         cfg_wr_data,
  input  wire ttps_cmd_t           cmd,
  output ttps_stat_t               stat,
  output logic [1:0]               out_status,
  output logic signed [15:0]       out_result_score,
  output logic [15:0]              out_result_move,
  output logic [9:0]               out_occupancy_permille
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = IW + 1;
  localparam int PW = CW + 10;

  // table memory
  logic [KEY_W-1:0] key_mem [ENTRIES];
  payload_t         pay_mem [ENTRIES];

  // latched item
  kind_t              kind_r;
  logic [63:0]        key_r;
  logic signed [15:0] alpha_r;
  logic signed [15:0] beta_r;
  logic [6:0]         depth_r;
  logic [6:0]         ply_r;
  logic signed [15:0] sscore_r;
  logic [1:0]         sflag_r;
  logic [15:0]        smove_r;

  logic [KEY_W-1:0] rd_key_r;
  payload_t         rd_pay_r;

  logic [14:0]  thr_r;
  logic [IW-1:0] sweep_cnt_r;
  logic [CW-1:0] count_r;

  logic [1:0]         status_r;
  logic signed [15:0] score_r;
  logic [15:0]        move_r;
  logic [9:0]         perm_r;

  // combinational
  logic signed [16:0] t_pos, t_neg, ply17;
  logic signed [16:0] p0, p1, p2, r0, r1;
  logic signed [15:0] p_sat;
  logic               hit, depth_ok, cut;
  logic signed [15:0] cut_score;
  logic               is_record;
  logic               we;
  logic [IW-1:0]      wa;
  logic [KEY_W-1:0]   wkey;
  payload_t           wpay;
  logic               old_nz, new_nz;
  logic [PW-1:0]      prod;
  logic [1:0]         status_nxt;
  logic signed [15:0] score_nxt;
  logic [15:0]        move_nxt;
  logic [9:0]         perm_nxt;

  always_comb begin
    t_pos = {2'b00, thr_r};
    t_neg = -t_pos;
    ply17 = {10'b0, ply_r};

    // probe: undo mate adjustment of the stored score
    p0 = {rd_pay_r.score[15], rd_pay_r.score};
    p1 = (p0 < t_neg) ? (p0 + ply17) : p0;
    p2 = (p1 > t_pos) ? (p1 - ply17) : p1;
    p_sat = sat16(p2);

    hit      = (rd_key_r == key_r);
    depth_ok = (rd_pay_r.depth >= depth_r);
    cut       = 1'b0;
    cut_score = '0;
    if (depth_ok) begin
      if (rd_pay_r.flag == FLAG_EXACT) begin
        cut       = 1'b1;
        cut_score = p_sat;
      end else if (rd_pay_r.flag == FLAG_UPPER && p_sat <= alpha_r) begin
        cut       = 1'b1;
        cut_score = alpha_r;
      end else if (rd_pay_r.flag == FLAG_LOWER && p_sat >= beta_r) begin
        cut       = 1'b1;
        cut_score = beta_r;
      end
    end

    // record: mate scores pushed away from the root
    r0 = {sscore_r[15], sscore_r};
    if (r0 > t_pos) begin
      r1 = r0 + ply17;
    end else if (r0 < t_neg) begin
      r1 = r0 - ply17;
    end else begin
      r1 = r0;
    end

    is_record = (kind_r == KIND_RECORD);
    we = cmd.sweep_step | (cmd.commit & is_record);
    if (cmd.sweep_step) begin
      wa   = sweep_cnt_r;
      wkey = '0;
      wpay = '0;
    end else begin
      wa         = key_r[IW-1:0];
      wkey       = key_r;
      wpay.score = sat16(r1);
      wpay.flag  = sflag_r;
      wpay.depth = depth_r;
      wpay.move  = smove_r;
    end

    old_nz = (rd_key_r != '0);
    new_nz = (key_r != '0);

    prod = {10'b0, count_r} * PW'(PERMILLE_SCALE);

    status_nxt = STAT_DONE;
    score_nxt  = '0;
    move_nxt   = '0;
    perm_nxt   = '0;
    unique case (kind_r)
      KIND_PROBE: begin
        if (!hit) begin
          status_nxt = STAT_MISS;
        end else if (cut) begin
          status_nxt = STAT_CUT;
          score_nxt  = cut_score;
        end else begin
          status_nxt = STAT_MOVE;
          move_nxt   = rd_pay_r.move;
        end
      end
      KIND_OCCUPANCY: perm_nxt = 10'(prod >> IW);
      KIND_RECORD, KIND_CLEAR: status_nxt = STAT_DONE;
      default: status_nxt = STAT_DONE;
    endcase

    stat.sweep_last = (sweep_cnt_r == IW'(ENTRIES - 1));
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wa] <= wkey;
      pay_mem[wa] <= wpay;
    end
    if (cmd.capture) begin
      rd_key_r <= key_mem[in_position_key[IW-1:0]];
      rd_pay_r <= pay_mem[in_position_key[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= kind_t'(in_kind);
      key_r    <= in_position_key;
      alpha_r  <= in_alpha_bound;
      beta_r   <= in_beta_bound;
      depth_r  <= in_search_depth;
      ply_r    <= in_ply_from_root;
      sscore_r <= in_store_score;
      sflag_r  <= in_store_flag;
      smove_r  <= in_store_move;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      score_r  <= score_nxt;
      move_r   <= move_nxt;
      perm_r   <= perm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= MATE_THR_RESET;
      sweep_cnt_r <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (cmd.sweep_start) begin
        sweep_cnt_r <= '0;
        count_r     <= '0;
      end else begin
        if (cmd.sweep_step) begin
          sweep_cnt_r <= sweep_cnt_r + 1'b1;
        end
        if (cmd.commit && is_record) begin
          if (!old_nz && new_nz) begin
            count_r <= count_r + 1'b1;
          end else if (old_nz && !new_nz && count_r != '0) begin
            count_r <= count_r - 1'b1;
          end
        end
      end
    end
  end

  assign out_status             = status_r;
  assign out_result_score       = score_r;
  assign out_result_move        = move_r;
  assign out_occupancy_permille = perm_r;

endmodule

`default_nettype wire

>>> src/transposition_table_probe_store.sv
// Direct-mapped transposition table: top level joining controller and datapath.
// Depends on ttps_pkg, ttps_ctrl, ttps_dp and the assertion macro header.
`include "transposition_table_probe_store_defines.svh"
`default_nettype none

// Direct-mapped transposition table of ENTRIES entries (a power of two),
// indexed by the low bits of the 64-bit key, with the full key kept as tag.
// Probe, record and occupancy are handled one item at a time: the block
// accepts the item and reads the entry from the table memory, then evaluates
// it from the registered read data and loads the result register once that
// register is free. Clear sweeps the table, zeroing one entry per cycle
// through the table's write port, then loads its result. After reset the same
// sweep runs with in_ready low and gives no result. A finished result
// waits in the output register while the next item is accepted. The mate
// threshold register may be written whenever the block is idle.
module transposition_table_probe_store
  import ttps_pkg::*;
#(
  parameter int ENTRIES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_kind,
  input  wire logic [63:0]        in_position_key,
  input  wire logic signed [15:0] in_alpha_bound,
  input  wire logic signed [15:0] in_beta_bound,
  input  wire logic [6:0]         in_search_depth,
  input  wire logic [6:0]         in_ply_from_root,
  input  wire logic signed [15:0] in_store_score,
  input  wire logic [1:0]         in_store_flag,
  input  wire logic [15:0]        in_store_move,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [15:0]      out_result_score,
  output logic [15:0]             out_result_move,
  output logic [9:0]              out_occupancy_permille,
  input  wire logic               cfg_wr_en,
  input  wire logic [14:0]        cfg_wr_data
);

  ttps_cmd_t  cmd;
  ttps_stat_t stat;

  ttps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttps_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_kind                (in_kind),
    .in_position_key        (in_position_key),
    .in_alpha_bound         (in_alpha_bound),
    .in_beta_bound          (in_beta_bound),
    .in_search_depth        (in_search_depth),
    .in_ply_from_root       (in_ply_from_root),
    .in_store_score         (in_store_score),
    .in_store_flag          (in_store_flag),
    .in_store_move          (in_store_move),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .cmd                    (cmd),
    .stat                   (stat),
    .out_status             (out_status),
    .out_result_score       (out_result_score),
    .out_result_move        (out_result_move),
    .out_occupancy_permille (out_occupancy_permille)
  );

  // a result only lands in a free or draining output register
  `TTPS_ASSERT(a_commit_slot, clk, rst_n, cmd.commit |-> (!out_valid || out_ready), "commit into a held result")
  `TTPS_ASSERT(a_commit_valid, clk, rst_n, cmd.commit |=> out_valid, "committed item not presented")
  // one item at a time
  `TTPS_ASSERT(a_one_item, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "item accepted while busy")
  `TTPS_ASSERT(a_sweep_blocks, clk, rst_n, cmd.sweep_step |-> (!in_ready && !cmd.commit), "accept or commit during sweep")

endmodule

`default_nettype wire

>>> dv/tb_transposition_table_probe_store.sv
// Self-checking testbench for transposition_table_probe_store.
// A queue-fed driver, a scoreboard monitor and a built-in table predictor.
// Depends on ttps_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_transposition_table_probe_store;
  import ttps_pkg::*;

  localparam int ENTRIES            = 4096;
  localparam int IDX_W              = 12;
  localparam logic [1:0] FLAG_UNUSED = 2'd3;
  localparam int RANDOM_PHASE_ITEMS = 326;
  localparam int PHASES             = 5;
  localparam int STALL_LIMIT        = 20000;
  localparam int KEY_POOL           = 32;
  localparam int HOLD_CYCLES        = 500;

  typedef struct {
    kind_t              kind;
    logic [63:0]        key;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [6:0]         depth;
    logic [6:0]         ply;
    logic signed [15:0] score;
    logic [1:0]         flag;
    logic [15:0]        move;
  } tt_op_t;

  typedef struct {
    status_t            status;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [9:0]         permille;
  } tt_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_kind = '0;
  logic [63:0]         in_position_key = '0;
  logic signed [15:0]  in_alpha_bound = '0;
  logic signed [15:0]  in_beta_bound = '0;
  logic [6:0]          in_search_depth = '0;
  logic [6:0]          in_ply_from_root = '0;
  logic signed [15:0]  in_store_score = '0;
  logic [1:0]          in_store_flag = '0;
  logic [15:0]         in_store_move = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic signed [15:0]  out_result_score;
  logic [15:0]         out_result_move;
  logic [9:0]          out_occupancy_permille;
  logic                cfg_wr_en = 1'b0;
  logic [14:0]         cfg_wr_data = '0;

  transposition_table_probe_store #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_position_key       (in_position_key),
    .in_alpha_bound        (in_alpha_bound),
    .in_beta_bound         (in_beta_bound),
    .in_search_depth       (in_search_depth),
    .in_ply_from_root      (in_ply_from_root),
    .in_store_score        (in_store_score),
    .in_store_flag         (in_store_flag),
    .in_store_move         (in_store_move),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_result_score      (out_result_score),
    .out_result_move       (out_result_move),
    .out_occupancy_permille(out_occupancy_permille),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] slot_tag [ENTRIES];
  payload_t    slot_body [ENTRIES];
  int          occupied;
  int          mate_thr;

  tt_op_t      op_queue [$];
  tt_result_t  expected_results [$];
  logic [63:0] key_pool [KEY_POOL];

  logic in_fire = 1'b0;
  int   mismatch_count = 0;
  int   accepted_items = 0;
  int   idle_cycles = 0;
  int   n_cut = 0, n_move = 0, n_miss = 0, n_record = 0, n_clear = 0, n_occ = 0;
  int   settings_used = 1;

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic tt_result_t tt_predict(input tt_op_t op);
    tt_result_t r;
    payload_t   body;
    int         idx;
    int         s;
    int         t;
    int         p;
    int         a;
    int         b;
    bit         cut;
    idx = op.key[IDX_W-1:0];
    t = mate_thr;
    p = op.ply;
    a = op.alpha;
    b = op.beta;
    r.status = STAT_DONE;
    r.score = '0;
    r.move = '0;
    r.permille = '0;
    case (op.kind)
      KIND_PROBE: begin
        r.status = STAT_MISS;
        if (slot_tag[idx] == op.key) begin
          body = slot_body[idx];
          s = $signed(body.score);
          cut = 1'b0;
          if (body.depth >= op.depth) begin
            // two separate tests, not an else chain
            if (s < -t) s = s + p;
            if (s > t) s = s - p;
            s = clip16(s);
            if (body.flag == FLAG_EXACT) begin
              cut = 1'b1;
              r.score = 16'(s);
            end else if (body.flag == FLAG_UPPER && s <= a) begin
              cut = 1'b1;
              r.score = op.alpha;
            end else if (body.flag == FLAG_LOWER && s >= b) begin
              cut = 1'b1;
              r.score = op.beta;
            end
          end
          if (cut) begin
            r.status = STAT_CUT;
          end else begin
            r.status = STAT_MOVE;
            r.move = body.move;
          end
        end
        case (r.status)
          STAT_CUT:  n_cut++;
          STAT_MOVE: n_move++;
          default:   n_miss++;
        endcase
      end
      KIND_RECORD: begin
        s = op.score;
        if (s > t) s = s + p;
        else if (s < -t) s = s - p;
        s = clip16(s);
        if (slot_tag[idx] == '0 && op.key != '0) occupied++;
        else if (slot_tag[idx] != '0 && op.key == '0 && occupied > 0) occupied--;
        slot_tag[idx] = op.key;
        body.score = 16'(s);
        body.flag = op.flag;
        body.depth = op.depth;
        body.move = op.move;
        slot_body[idx] = body;
        n_record++;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          slot_tag[i] = '0;
          slot_body[i] = '0;
        end
        occupied = 0;
        n_clear++;
      end
      default: begin
        s = (occupied * PERMILLE_SCALE) / ENTRIES;
        r.permille = (s > PERMILLE_SCALE) ? 10'(PERMILLE_SCALE) : 10'(s);
        n_occ++;
      end
    endcase
    return r;
  endfunction

  function automatic tt_op_t make_op(input kind_t k, input logic [63:0] key, input int alpha,
                                     input int beta, input int depth, input int ply,
                                     input int score, input logic [1:0] flag, input int move);
    tt_op_t op;
    op.kind = k;
    op.key = key;
    op.alpha = 16'(alpha);
    op.beta = 16'(beta);
    op.depth = 7'(depth);
    op.ply = 7'(ply);
    op.score = 16'(score);
    op.flag = flag;
    op.move = 16'(move);
    return op;
  endfunction

  // mostly small window scores, some around the mate threshold, some extremes
  function automatic int pick_score(input int thr);
    int v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = $urandom_range(0, 600);
      v = v - 300;
    end else if (r < 70) begin
      v = $urandom_range(0, 300);
      v = thr + v - 150;
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 85) begin
      v = $urandom_range(0, 65535);
      v = v - 32768;
    end else begin
      v = $urandom_range(0, 200);
      v = ($urandom_range(0, 1)) ? 32767 - v : -32768 + v;
    end
    return clip16(v);
  endfunction

  function automatic tt_op_t random_op(input int thr);
    tt_op_t      op;
    logic [63:0] key;
    int          r;
    kind_t       k;
    if ($urandom_range(0, 99) < 6) key = {$urandom, $urandom};
    else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    if ($urandom_range(0, 99) < 3) key_pool[$urandom_range(2, KEY_POOL - 1)] = {$urandom, $urandom};
    r = $urandom_range(0, 999);
    if (r < 10) k = KIND_CLEAR;
    else if (r < 80) k = KIND_OCCUPANCY;
    else if (r < 540) k = KIND_PROBE;
    else k = KIND_RECORD;
    op = make_op(k, key, pick_score(thr), pick_score(thr),
                 ($urandom_range(0, 9) < 6) ? $urandom_range(0, 15) : $urandom_range(0, 127),
                 $urandom_range(0, 127), pick_score(thr),
                 ($urandom_range(0, 9) == 0) ? FLAG_UNUSED : 2'($urandom_range(0, 2)),
                 $urandom_range(0, 65535));
    return op;
  endfunction

  // sampled at the rising edge, where the driver's outputs are settled
  task automatic wait_idle();
    while (op_queue.size() != 0 || in_valid || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_mate_threshold(input logic [14:0] v);
    wait_idle();
    repeat (8) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mate_thr = v;
    settings_used++;
  endtask

  // driver: bursts of items separated by random gaps
  int     burst_left = 0;
  int     gap_left = 0;
  tt_op_t cur;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        cur = op_queue.pop_front();
        in_kind <= cur.kind;
        in_position_key <= cur.key;
        in_alpha_bound <= cur.alpha;
        in_beta_bound <= cur.beta;
        in_search_depth <= cur.depth;
        in_ply_from_root <= cur.ply;
        in_store_score <= cur.score;
        in_store_flag <= cur.flag;
        in_store_move <= cur.move;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall modes, plus two long hold-offs to back up the input
  int          hold_left = 0;
  int          holds_done = 0;
  int          mode_left = 0;
  int          ready_mode = 0;
  logic [15:0] stall_pattern = 16'hFFFF;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && accepted_items >= ((holds_done == 0) ? 400 : 1200)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
        stall_pattern = 16'($urandom);
      end
      mode_left--;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 9) != 0);
        default: begin
          out_ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
      endcase
    end
  end

  // monitor: check results against the oldest prediction, predict accepted items
  always @(posedge clk) begin : monitor
    tt_result_t want;
    tt_op_t     op;
    in_fire <= in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] result with no item outstanding: status %0d score %0d move %h permille %0d",
                   $realtime, out_status, out_result_score, out_result_move,
                   out_occupancy_permille);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_result_score !== want.score ||
            out_result_move !== want.move || out_occupancy_permille !== want.permille) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch: expected status %0d score %0d move %h permille %0d, got status %0d score %0d move %h permille %0d",
                     $realtime, want.status, want.score, want.move, want.permille,
                     out_status, out_result_score, out_result_move, out_occupancy_permille);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      op = make_op(kind_t'(in_kind), in_position_key, in_alpha_bound, in_beta_bound,
                   in_search_depth, in_ply_from_root, in_store_score, in_store_flag,
                   in_store_move);
      expected_results.push_back(tt_predict(op));
      accepted_items++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [14:0] phase_thr [PHASES];
    for (int i = 0; i < ENTRIES; i++) begin
      slot_tag[i] = '0;
      slot_body[i] = '0;
    end
    occupied = 0;
    mate_thr = MATE_THR_RESET;
    phase_thr = '{15'd0, 15'd32767, 15'd100, 15'($urandom_range(1, 32766)), MATE_THR_RESET};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: cleared-entry hits on key zero, mate adjustment both ways with
    // saturation, each bound kind cutting and not, flag three, tag alias miss,
    // occupancy count up and down, clear
    op_queue.push_back(make_op(KIND_PROBE, 64'h0, -32768, 32767, 0, 0, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_PROBE, 64'h0, 32767, -32768, 127, 127, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_OCCUPANCY, 64'h0, 0, 0, 0, 0, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 10, 10, 29500,
                               FLAG_EXACT, 16'hFFFF));
    op_queue.push_back(make_op(KIND_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 10, 3, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 11, 3, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_PROBE, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_RECORD, 64'h0123_4567_89AB_C001, 0, 0, 127, 127, -29500,
                               FLAG_UPPER, 0));
    op_queue.push_back(make_op(KIND_PROBE, 64'h0123_4567_89AB_C001, -29000, 0, 127, 0, 0,
                               FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_PROBE, 64'h0123_4567_89AB_C001, -32768, 0, 127, 0, 0,
                               FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_RECORD, 64'h5555_5555_5555_5002, 0, 0, 3, 5, 100,
                               FLAG_LOWER, 16'h1234));
    op_queue.push_back(make_op(KIND_PROBE, 64'h5555_5555_5555_5002, 0, 100, 0, 5, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_PROBE, 64'h5555_5555_5555_5002, 0, 101, 0, 5, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_RECORD, 64'hAAAA_AAAA_AAAA_A003, 0, 0, 4, 0, 0,
                               FLAG_UNUSED, 16'hABCD));
    op_queue.push_back(make_op(KIND_PROBE, 64'hAAAA_AAAA_AAAA_A003, 32767, -32768, 0, 0, 0,
                               FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_RECORD, 64'h0F0F_0F0F_0F0F_0004, 0, 0, 20, 127, 32767,
                               FLAG_EXACT, 1));
    op_queue.push_back(make_op(KIND_PROBE, 64'h0F0F_0F0F_0F0F_0004, 0, 0, 20, 0, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_RECORD, 64'hF0F0_F0F0_F0F0_0005, 0, 0, 20, 127, -32768,
                               FLAG_EXACT, 2));
    op_queue.push_back(make_op(KIND_PROBE, 64'hF0F0_F0F0_F0F0_0005, 0, 0, 20, 127, 0,
                               FLAG_EXACT, 0));
    // nonzero tag at entry zero, then overwritten by key zero: count goes up and back down
    op_queue.push_back(make_op(KIND_RECORD, 64'h0000_0001_0000_0000, 0, 0, 1, 0, 7, FLAG_EXACT, 3));
    op_queue.push_back(make_op(KIND_RECORD, 64'h0, 0, 0, 1, 0, 7, FLAG_EXACT, 3));
    op_queue.push_back(make_op(KIND_OCCUPANCY, 64'h0, 0, 0, 0, 0, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_CLEAR, 64'h0, 0, 0, 0, 0, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, FLAG_EXACT, 0));
    op_queue.push_back(make_op(KIND_OCCUPANCY, 64'h0, 0, 0, 0, 0, 0, FLAG_EXACT, 0));

    // key pool: key zero, a nonzero key on entry zero, and tag aliases sharing an index
    key_pool[0] = 64'h0;
    key_pool[1] = {$urandom, 20'($urandom), 12'h000};
    for (int i = 2; i < KEY_POOL; i++) begin
      if (i % 4 == 3) key_pool[i] = {$urandom, 20'($urandom), key_pool[i-1][IDX_W-1:0]};
      else key_pool[i] = {$urandom, $urandom};
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_mate_threshold(phase_thr[ph]);
      for (int n = 0; n < RANDOM_PHASE_ITEMS; n++) op_queue.push_back(random_op(mate_thr));
    end

    wait_idle();
    repeat (20) @(negedge clk);
    $display("Ran %0d items over %0d mate threshold settings: %0d records, %0d clears, %0d occupancy queries",
             accepted_items, settings_used, n_record, n_clear, n_occ);
    $display("Probes gave %0d cutoffs, %0d move-only hits and %0d misses", n_cut, n_move, n_miss);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, expected_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/ttps_pkg.sv
src/ttps_ctrl.sv
src/ttps_dp.sv
src/transposition_table_probe_store.sv
dv/tb_transposition_table_probe_store.sv
